// ----- design/flaq_pkg.sv -----
// Shared types and constants of the first-come lock arbiter.
package flaq_pkg;

   localparam int unsigned IdWidth = 64;
   localparam int unsigned AgeWidth = 16;

   // Input actions
   localparam logic [3:0] ACT_TICK       = 4'd0;
   localparam logic [3:0] ACT_REGISTER   = 4'd1;
   localparam logic [3:0] ACT_REQUEST    = 4'd2;
   localparam logic [3:0] ACT_RELEASE    = 4'd3;
   localparam logic [3:0] ACT_HEARTBEAT  = 4'd4;
   localparam logic [3:0] ACT_DISCONNECT = 4'd5;
   localparam logic [3:0] ACT_ON         = 4'd6;
   localparam logic [3:0] ACT_OFF        = 4'd7;
   localparam logic [3:0] ACT_CONNECT    = 4'd8;

   // Result message types
   localparam logic [2:0] MSG_GRANT  = 3'd0;
   localparam logic [2:0] MSG_DROP   = 3'd1;
   localparam logic [2:0] MSG_ON     = 3'd2;
   localparam logic [2:0] MSG_OFF    = 3'd3;
   localparam logic [2:0] MSG_CLOSED = 3'd4;

   // Slot status codes
   localparam logic [1:0] ST_EMPTY = 2'd0;
   localparam logic [1:0] ST_CONN  = 2'd1;
   localparam logic [1:0] ST_REG   = 2'd2;

   // Configuration register indexes
   localparam logic [0:0] CSR_QUANTUM = 1'd0;
   localparam logic [0:0] CSR_TIMEOUT = 1'd1;

   localparam logic [AgeWidth-1:0] CfgResetValue = 16'd30;

   typedef enum logic [2:0] {
      SOP_NONE,
      SOP_CONN,
      SOP_REG,
      SOP_HB,
      SOP_FREE,
      SOP_TICK
   } slot_op_type;

   typedef struct packed {
      slot_op_type         op;
      logic [AgeWidth-1:0] timeout;
   } slot_ctrl_type;

   typedef struct packed {
      logic               flush;
      logic               rm_en;
      logic [3:0]         rm_slot;
      logic               ins_en;
      logic [3:0]         ins_slot;
      logic [IdWidth-1:0] ins_id;
   } queue_ctrl_type;

   typedef struct packed {
      logic [2:0]         msg;
      logic [3:0]         slot;
      logic [IdWidth-1:0] id;
   } result_type;

endpackage

// ----- design/flaq_if.sv -----
// Valid/ready channel interfaces for event words and result words.
interface flaq_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  action;
   logic [3:0]  client_slot;
   logic [63:0] request_id;

   modport source (output valid, action, client_slot, request_id, input ready);
   modport sink (input valid, action, client_slot, request_id, output ready);
endinterface

interface flaq_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  message_type;
   logic [3:0]  target_slot;
   logic [63:0] echoed_request_id;
   logic        last;

   modport source (output valid, message_type, target_slot, echoed_request_id, last,
                   input ready);
   modport sink (input valid, message_type, target_slot, echoed_request_id, last,
                 output ready);
endinterface

// ----- design/flaq_queue_cell.sv -----
// One entry of the request queue; pulls from its successor to close gaps.
module flaq_queue_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  flaq_pkg::queue_ctrl_type          ctrl,
   input  logic                              prv_valid,
   input  logic                              nxt_valid,
   input  logic [3:0]                        nxt_slot,
   input  logic [flaq_pkg::IdWidth-1:0]      nxt_id,
   output logic                              valid,
   output logic [3:0]                        slot,
   output logic [flaq_pkg::IdWidth-1:0]      id
);

   logic                         valid_ff, valid_in;
   logic [3:0]                   slot_ff, slot_in;
   logic [flaq_pkg::IdWidth-1:0] id_ff, id_in;

   always_comb begin
      valid_in = valid_ff;
      slot_in  = slot_ff;
      id_in    = id_ff;
      if (ctrl.flush) begin
         valid_in = 1'b0;
      end else if (ctrl.rm_en && valid_ff && slot_ff == ctrl.rm_slot) begin
         valid_in = 1'b0;
      end else if (ctrl.ins_en && !valid_ff && prv_valid) begin
         // First free entry takes the new word.
         valid_in = 1'b1;
         slot_in  = ctrl.ins_slot;
         id_in    = ctrl.ins_id;
      end else if (!valid_ff && nxt_valid) begin
         valid_in = 1'b1;
         slot_in  = nxt_slot;
         id_in    = nxt_id;
      end else if (valid_ff && !prv_valid) begin
         // The gap ahead pulls this entry forward.
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      slot_ff <= slot_in;
      id_ff   <= id_in;
   end

   assign valid = valid_ff;
   assign slot  = slot_ff;
   assign id    = id_ff;

endmodule

// ----- design/flaq_slot_cell.sv -----
// Status and heartbeat age of one client slot.
module flaq_slot_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          sel,
   input  flaq_pkg::slot_ctrl_type       ctrl,
   output logic [1:0]                    status,
   output logic                          close_pend
);

   logic [1:0]                    status_ff, status_in;
   logic [flaq_pkg::AgeWidth-1:0] age_ff, age_in, age_inc;
   logic                          pend_ff, pend_in;

   assign age_inc = (age_ff == '1) ? age_ff : age_ff + 1'b1;

   always_comb begin
      status_in = status_ff;
      age_in    = age_ff;
      pend_in   = pend_ff;
      case (ctrl.op)
         flaq_pkg::SOP_TICK: begin
            if (status_ff != flaq_pkg::ST_EMPTY) begin
               age_in = age_inc;
            end
            pend_in = (status_ff == flaq_pkg::ST_REG) && (age_inc > ctrl.timeout);
         end
         flaq_pkg::SOP_CONN: begin
            if (sel) begin
               status_in = flaq_pkg::ST_CONN;
               age_in    = '0;
            end
         end
         flaq_pkg::SOP_REG: begin
            if (sel) begin
               status_in = flaq_pkg::ST_REG;
               age_in    = '0;
            end
         end
         flaq_pkg::SOP_HB: begin
            if (sel) begin
               age_in = '0;
            end
         end
         flaq_pkg::SOP_FREE: begin
            if (sel) begin
               status_in = flaq_pkg::ST_EMPTY;
               age_in    = '0;
               pend_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= flaq_pkg::ST_EMPTY;
         age_ff    <= '0;
         pend_ff   <= 1'b0;
      end else begin
         status_ff <= status_in;
         age_ff    <= age_in;
         pend_ff   <= pend_in;
      end
   end

   assign status     = status_ff;
   assign close_pend = pend_ff;

endmodule

// ----- design/fcfs_lock_arbiter_with_quantum.sv -----
// Top level: first-come lock arbiter with time quantum and heartbeat supervision.
// Event words are taken one at a time; the block is ready again once the last
// result word of the previous event sits in the output register. A removal
// from the request queue opens a gap that the row of queue cells closes one
// entry per cycle. Scheduling on and off walk all SLOTS slot cells, one per
// cycle while the result path is free; a tick does the same and adds one gap
// closing per client it closes.
// A result word that is not taken holds the walk when the next word is ready.
module fcfs_lock_arbiter_with_quantum #(
   parameter int unsigned SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   flaq_req_if.sink    req_ch,
   flaq_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int unsigned SW = $clog2(SLOTS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_DROP,
      S_GRANT,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [3:0]                    act_ff;
   logic [3:0]                    act_slot_ff;
   logic [flaq_pkg::IdWidth-1:0]  act_id_ff;
   logic [SW-1:0]                 scan_ff, scan_in;
   logic                          scan_close_ff, scan_close_in;
   logic [2:0]                    scan_msg_ff, scan_msg_in;
   logic                          busy_ff, busy_in;
   logic                          sched_ff, sched_in;
   logic [flaq_pkg::AgeWidth-1:0] hold_age_ff, hold_age_in, hold_inc;
   logic                          drop_sent_ff, drop_sent_in;
   logic [flaq_pkg::IdWidth-1:0]  holder_id_ff, holder_id_in;
   logic [flaq_pkg::AgeWidth-1:0] quantum_ff, quantum_in;
   logic [flaq_pkg::AgeWidth-1:0] timeout_ff, timeout_in;
   flaq_pkg::result_type          pend_ff, pend_in;
   logic                          pend_v_ff, pend_v_in;
   flaq_pkg::result_type          out_ff, out_in;
   logic                          out_v_ff, out_v_in;
   logic                          out_last_ff, out_last_in;

   flaq_pkg::queue_ctrl_type      qctrl;
   flaq_pkg::slot_ctrl_type       sctrl;
   logic                          emit_en;
   flaq_pkg::result_type          emit_res;

   logic [SLOTS-1:0]              qv;
   logic [3:0]                    qslot [SLOTS];
   logic [flaq_pkg::IdWidth-1:0]  qid [SLOTS];
   logic [SLOTS-1:0]              dup_vec;
   logic [SLOTS-1:0]              hole_vec;
   logic [1:0]                    st_arr [SLOTS];
   logic [SLOTS-1:0]              pend_arr;

   logic [SW-1:0]                 rd_idx;
   logic [1:0]                    cur_st;
   logic                          cur_pend;
   logic [3:0]                    cur_slot;
   logic                          slot_ok;
   logic                          q_hole;
   logic                          dup;
   logic                          full;
   logic                          out_free;
   logic                          can_emit;
   logic                          head_hit;

   // Queue cells: entry 0 is the head and holds the lock.
   for (genvar i = 0; i < SLOTS; i++) begin : g_queue
      logic                         nv;
      logic [3:0]                   ns;
      logic [flaq_pkg::IdWidth-1:0] nid;
      logic                         pv;
      if (i == SLOTS - 1) begin : g_tail
         assign nv  = 1'b0;
         assign ns  = '0;
         assign nid = '0;
      end else begin : g_mid
         assign nv  = qv[i+1];
         assign ns  = qslot[i+1];
         assign nid = qid[i+1];
      end
      if (i == 0) begin : g_head
         assign pv = 1'b1;
      end else begin : g_body
         assign pv = qv[i-1];
      end
      flaq_queue_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (qctrl),
         .prv_valid (pv),
         .nxt_valid (nv),
         .nxt_slot  (ns),
         .nxt_id    (nid),
         .valid     (qv[i]),
         .slot      (qslot[i]),
         .id        (qid[i])
      );
      assign dup_vec[i] = qv[i] && (qslot[i] == act_slot_ff);
      if (i == SLOTS - 1) begin : g_hole_tail
         assign hole_vec[i] = 1'b0;
      end else begin : g_hole_mid
         assign hole_vec[i] = !qv[i] && qv[i+1];
      end
   end

   for (genvar i = 0; i < SLOTS; i++) begin : g_slot
      flaq_slot_cell u_slot (
         .clock      (clock),
         .reset      (reset),
         .sel        (rd_idx == SW'(i)),
         .ctrl       (sctrl),
         .status     (st_arr[i]),
         .close_pend (pend_arr[i])
      );
   end

   assign q_hole   = |hole_vec;
   assign dup      = |dup_vec;
   assign full     = qv[SLOTS-1];
   assign rd_idx   = (state_ff == S_SCAN) ? scan_ff : SW'(act_slot_ff);
   assign cur_st   = st_arr[rd_idx];
   assign cur_pend = pend_arr[rd_idx];
   assign cur_slot = (state_ff == S_SCAN) ? 4'(scan_ff) : act_slot_ff;
   assign slot_ok  = 32'(act_slot_ff) < 32'(SLOTS);
   assign head_hit = qv[0] && (qslot[0] == cur_slot);
   assign out_free = !out_v_ff || rsp_ch.ready;
   assign can_emit = !pend_v_ff || out_free;
   assign hold_inc = (hold_age_ff == '1) ? hold_age_ff : hold_age_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      scan_close_in = scan_close_ff;
      scan_msg_in   = scan_msg_ff;
      busy_in       = busy_ff;
      sched_in      = sched_ff;
      hold_age_in   = hold_age_ff;
      drop_sent_in  = drop_sent_ff;
      holder_id_in  = holder_id_ff;
      quantum_in    = quantum_ff;
      timeout_in    = timeout_ff;
      pend_in       = pend_ff;
      pend_v_in     = pend_v_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_v_in      = out_v_ff && !rsp_ch.ready;
      qctrl         = '0;
      qctrl.rm_slot = cur_slot;
      qctrl.ins_slot = act_slot_ff;
      qctrl.ins_id  = act_id_ff;
      sctrl.op      = flaq_pkg::SOP_NONE;
      sctrl.timeout = timeout_ff;
      emit_en       = 1'b0;
      emit_res      = '0;
      emit_res.slot = cur_slot;

      // Every step waits until the queue cells have closed any gap.
      if (!q_hole) begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  state_in = S_EXEC;
               end
            end
            S_EXEC: begin
               if (can_emit) begin
                  state_in = S_FINISH;
                  case (act_ff) inside
                     flaq_pkg::ACT_TICK: begin
                        sctrl.op      = flaq_pkg::SOP_TICK;
                        scan_in       = '0;
                        scan_close_in = 1'b1;
                        state_in      = S_SCAN;
                     end
                     flaq_pkg::ACT_ON: begin
                        if (!sched_ff) begin
                           sched_in      = 1'b1;
                           scan_in       = '0;
                           scan_close_in = 1'b0;
                           scan_msg_in   = flaq_pkg::MSG_ON;
                           state_in      = S_SCAN;
                        end
                     end
                     flaq_pkg::ACT_OFF: begin
                        if (sched_ff) begin
                           sched_in      = 1'b0;
                           scan_in       = '0;
                           scan_close_in = 1'b0;
                           scan_msg_in   = flaq_pkg::MSG_OFF;
                           state_in      = S_SCAN;
                        end
                     end
                     flaq_pkg::ACT_CONNECT: begin
                        if (slot_ok && cur_st == flaq_pkg::ST_EMPTY) begin
                           sctrl.op = flaq_pkg::SOP_CONN;
                        end
                     end
                     flaq_pkg::ACT_REGISTER, flaq_pkg::ACT_REQUEST,
                     flaq_pkg::ACT_RELEASE, flaq_pkg::ACT_HEARTBEAT,
                     flaq_pkg::ACT_DISCONNECT: begin
                        if (slot_ok && cur_st != flaq_pkg::ST_EMPTY) begin
                           state_in = S_GRANT;
                           if (act_ff == flaq_pkg::ACT_HEARTBEAT) begin
                              sctrl.op = flaq_pkg::SOP_HB;
                           end else if (act_ff == flaq_pkg::ACT_DISCONNECT) begin
                              sctrl.op    = flaq_pkg::SOP_FREE;
                              qctrl.rm_en = 1'b1;
                              if (head_hit) begin
                                 busy_in = 1'b0;
                              end
                           end else if (act_ff == flaq_pkg::ACT_REGISTER &&
                                        cur_st == flaq_pkg::ST_CONN) begin
                              sctrl.op     = flaq_pkg::SOP_REG;
                              emit_en      = 1'b1;
                              emit_res.msg = sched_ff ? flaq_pkg::MSG_ON : flaq_pkg::MSG_OFF;
                           end else if (act_ff == flaq_pkg::ACT_REGISTER ||
                                        cur_st != flaq_pkg::ST_REG) begin
                              // Protocol violation: the client is closed.
                              sctrl.op     = flaq_pkg::SOP_FREE;
                              qctrl.rm_en  = 1'b1;
                              emit_en      = 1'b1;
                              emit_res.msg = flaq_pkg::MSG_CLOSED;
                              if (head_hit) begin
                                 busy_in = 1'b0;
                              end
                           end else if (act_ff == flaq_pkg::ACT_REQUEST) begin
                              qctrl.ins_en = sched_ff && !dup && !full;
                           end else if (sched_ff) begin
                              qctrl.rm_en = 1'b1;
                              if (head_hit) begin
                                 busy_in = 1'b0;
                              end
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_SCAN: begin
               if (can_emit) begin
                  if (scan_close_ff) begin
                     if (cur_pend) begin
                        sctrl.op     = flaq_pkg::SOP_FREE;
                        qctrl.rm_en  = 1'b1;
                        emit_en      = 1'b1;
                        emit_res.msg = flaq_pkg::MSG_CLOSED;
                        if (head_hit) begin
                           busy_in = 1'b0;
                        end
                     end
                  end else if (cur_st == flaq_pkg::ST_REG) begin
                     emit_en      = 1'b1;
                     emit_res.msg = scan_msg_ff;
                  end
                  if (scan_ff == SW'(SLOTS - 1)) begin
                     if (scan_close_ff) begin
                        state_in = S_DROP;
                     end else begin
                        if (scan_msg_ff == flaq_pkg::MSG_OFF) begin
                           qctrl.flush = 1'b1;
                           busy_in     = 1'b0;
                        end
                        state_in = S_FINISH;
                     end
                  end else begin
                     scan_in = scan_ff + 1'b1;
                  end
               end
            end
            S_DROP: begin
               if (can_emit) begin
                  state_in = S_GRANT;
                  if (busy_ff && qv[0]) begin
                     hold_age_in = hold_inc;
                     if (hold_inc >= quantum_ff && !drop_sent_ff) begin
                        drop_sent_in  = 1'b1;
                        emit_en       = 1'b1;
                        emit_res.msg  = flaq_pkg::MSG_DROP;
                        emit_res.slot = qslot[0];
                        emit_res.id   = holder_id_ff;
                     end
                  end
               end
            end
            S_GRANT: begin
               if (can_emit) begin
                  state_in = S_FINISH;
                  if (sched_ff && !busy_ff && qv[0]) begin
                     busy_in       = 1'b1;
                     holder_id_in  = qid[0];
                     hold_age_in   = '0;
                     drop_sent_in  = 1'b0;
                     emit_en       = 1'b1;
                     emit_res.msg  = flaq_pkg::MSG_GRANT;
                     emit_res.slot = qslot[0];
                     emit_res.id   = qid[0];
                  end
               end
            end
            S_FINISH: begin
               // The word held back is the last one of this event.
               if (!pend_v_ff) begin
                  state_in = S_IDLE;
               end else if (out_free) begin
                  out_in      = pend_ff;
                  out_last_in = 1'b1;
                  out_v_in    = 1'b1;
                  pend_v_in   = 1'b0;
                  state_in    = S_IDLE;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end

      // One word is held back so that the following one decides its last flag.
      if (emit_en) begin
         if (pend_v_ff) begin
            out_in      = pend_ff;
            out_last_in = 1'b0;
            out_v_in    = 1'b1;
         end
         pend_in   = emit_res;
         pend_v_in = 1'b1;
      end

      if (csr_we) begin
         if (csr_index == flaq_pkg::CSR_QUANTUM) begin
            quantum_in   = csr_wdata;
            hold_age_in  = '0;
            drop_sent_in = 1'b0;
         end else begin
            timeout_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         scan_ff       <= '0;
         scan_close_ff <= 1'b0;
         scan_msg_ff   <= flaq_pkg::MSG_ON;
         busy_ff       <= 1'b0;
         sched_ff      <= 1'b1;
         hold_age_ff   <= '0;
         drop_sent_ff  <= 1'b0;
         holder_id_ff  <= '0;
         quantum_ff    <= flaq_pkg::CfgResetValue;
         timeout_ff    <= flaq_pkg::CfgResetValue;
         pend_v_ff     <= 1'b0;
         out_v_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         scan_close_ff <= scan_close_in;
         scan_msg_ff   <= scan_msg_in;
         busy_ff       <= busy_in;
         sched_ff      <= sched_in;
         hold_age_ff   <= hold_age_in;
         drop_sent_ff  <= drop_sent_in;
         holder_id_ff  <= holder_id_in;
         quantum_ff    <= quantum_in;
         timeout_ff    <= timeout_in;
         pend_v_ff     <= pend_v_in;
         out_v_ff      <= out_v_in;
      end
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      if (state_ff == S_IDLE && req_ch.valid && !q_hole) begin
         act_ff      <= req_ch.action;
         act_slot_ff <= req_ch.client_slot;
         act_id_ff   <= req_ch.request_id;
      end
   end

   assign req_ch.ready             = (state_ff == S_IDLE) && !q_hole;
   assign rsp_ch.valid             = out_v_ff;
   assign rsp_ch.message_type      = out_ff.msg;
   assign rsp_ch.target_slot       = out_ff.slot;
   assign rsp_ch.echoed_request_id = out_ff.id;
   assign rsp_ch.last              = out_last_ff;

endmodule
